@@ src/tsf_pkg.sv @@
`default_nettype none

package tsf_pkg;

  typedef logic [7:0] pixel_t;
  typedef logic [1:0] count_t;

  typedef struct packed {
    pixel_t pix;
    pixel_t lim;
  } cell_t;

  typedef struct packed {
    logic shift;
    logic fill;
  } cell_ctrl_t;

  typedef enum logic [2:0] {
    PH_MAIN   = 3'b001,
    PH_FLUSH1 = 3'b010,
    PH_FLUSH2 = 3'b100
  } phase_t;

  localparam int     NumCells   = 4;
  localparam count_t SeenMax    = 2'd2;
  localparam int     CentreMult = 2;
  localparam int     SumShift   = 3;
  localparam int     SumW       = 11;

endpackage

`default_nettype wire

@@ src/tsf_if.sv @@
`default_nettype none

interface tsf_col_if;
  logic            valid;
  logic            ready;
  tsf_pkg::pixel_t above_two;
  tsf_pkg::pixel_t above_one;
  tsf_pkg::pixel_t center_pixel;
  tsf_pkg::pixel_t below_one;
  tsf_pkg::pixel_t below_two;
  tsf_pkg::pixel_t flat_limit;
  logic            row_end;

  modport source (
    output valid, above_two, above_one, center_pixel, below_one, below_two,
           flat_limit, row_end,
    input  ready
  );
  modport sink (
    input  valid, above_two, above_one, center_pixel, below_one, below_two,
           flat_limit, row_end,
    output ready
  );
endinterface

interface tsf_res_if;
  logic            valid;
  logic            ready;
  tsf_pkg::pixel_t out_pixel;
  logic            row_done;
  logic            burst_last;

  modport source (output valid, out_pixel, row_done, burst_last, input ready);
  modport sink (input valid, out_pixel, row_done, burst_last, output ready);
endinterface

`default_nettype wire

@@ src/tsf_smooth5.sv @@
`default_nettype none

module tsf_smooth5 (
  input  tsf_pkg::pixel_t a2,
  input  tsf_pkg::pixel_t a1,
  input  tsf_pkg::pixel_t c,
  input  tsf_pkg::pixel_t b1,
  input  tsf_pkg::pixel_t b2,
  input  tsf_pkg::pixel_t lim,
  output tsf_pkg::pixel_t y
);

  function automatic tsf_pkg::pixel_t absdiff(tsf_pkg::pixel_t x, tsf_pkg::pixel_t z);
    return (x > z) ? (x - z) : (z - x);
  endfunction

  logic                      flat;
  logic [tsf_pkg::SumW-1:0]  sum;
  logic [tsf_pkg::SumW-1:0]  avg;

  assign flat = (absdiff(c, a2) < lim) && (absdiff(c, a1) < lim) &&
                (absdiff(c, b1) < lim) && (absdiff(c, b2) < lim);

  assign sum = {3'b000, a2} + {3'b000, a1} +
               ({3'b000, c} << tsf_pkg::CentreMult) +
               {3'b000, b1} + {3'b000, b2};

  assign avg = sum >> tsf_pkg::SumShift;
  assign y   = flat ? avg[7:0] : c;

endmodule

`default_nettype wire

@@ src/tsf_cell.sv @@
`default_nettype none

module tsf_cell (
  input  logic                clk,
  input  tsf_pkg::cell_ctrl_t ctrl,
  input  tsf_pkg::cell_t      fill_val,
  input  tsf_pkg::cell_t      shift_val,
  output tsf_pkg::cell_t      value
);

  always_ff @(posedge clk) begin
    if (ctrl.shift) begin
      value <= ctrl.fill ? fill_val : shift_val;
    end
  end

endmodule

`default_nettype wire

@@ src/thresholded_cross_smoothing_filter.sv @@
`default_nettype none

// Two-pass 5-tap deblock smoother over a pixel row, one column per transaction.
// The vertical pass is taken as a column is accepted; the horizontal pass runs
// over a chain of four window cells plus the newest column, with one shared
// evaluator. Throughput is one column per cycle unless result.ready stalls; a
// row_end column holds the evaluator through the main and both flush phases as
// the window is flushed with the replicated edge pixel. A result is registered
// by the step completing its window; a row's first two columns give none.

module thresholded_cross_smoothing_filter (
  input  logic      clk,
  input  logic      rst,
  tsf_col_if.sink   column,
  tsf_res_if.source result
);

  localparam int NumCells = tsf_pkg::NumCells;

  tsf_pkg::pixel_t     vert;
  tsf_pkg::pixel_t     horiz;

  logic                in_valid;
  tsf_pkg::pixel_t     in_v;
  tsf_pkg::pixel_t     in_lim;
  logic                in_last;

  tsf_pkg::phase_t     phase;
  tsf_pkg::phase_t     phase_next;
  tsf_pkg::count_t     seen;

  logic                step;
  logic                consume;
  logic                emit;
  logic                emit_done;
  logic                emit_blast;

  logic                out_valid;
  tsf_pkg::pixel_t     out_pix;
  logic                out_done;
  logic                out_blast;

  tsf_pkg::cell_ctrl_t cell_ctrl;
  tsf_pkg::cell_t      incoming;
  tsf_pkg::cell_t      cells [NumCells];
  tsf_pkg::cell_t      nbr   [NumCells];

  // vertical pass
  tsf_smooth5 u_vert (
    .a2  (column.above_two),
    .a1  (column.above_one),
    .c   (column.center_pixel),
    .b1  (column.below_one),
    .b2  (column.below_two),
    .lim (column.flat_limit),
    .y   (vert)
  );

  assign step    = in_valid && (!out_valid || result.ready);
  assign consume = step && ((phase == tsf_pkg::PH_FLUSH2) ||
                            ((phase == tsf_pkg::PH_MAIN) && !in_last));
  assign column.ready = !in_valid || consume;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (column.ready) begin
      in_valid <= column.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (column.ready && column.valid) begin
      in_v    <= vert;
      in_lim  <= column.flat_limit;
      in_last <= column.row_end;
    end
  end

  // window cells
  assign incoming        = '{pix: in_v, lim: in_lim};
  assign cell_ctrl.shift = step;
  assign cell_ctrl.fill  = (phase == tsf_pkg::PH_MAIN) && (seen == '0);

  for (genvar k = 0; k < NumCells; k++) begin : g_cell
    if (k == NumCells - 1) begin : g_tail
      assign nbr[k] = incoming;
    end else begin : g_body
      assign nbr[k] = cells[k+1];
    end

    tsf_cell u_cell (
      .clk       (clk),
      .ctrl      (cell_ctrl),
      .fill_val  (incoming),
      .shift_val (nbr[k]),
      .value     (cells[k])
    );
  end

  // horizontal pass, centred on cell two
  tsf_smooth5 u_horiz (
    .a2  (cells[0].pix),
    .a1  (cells[1].pix),
    .c   (cells[2].pix),
    .b1  (cells[3].pix),
    .b2  (in_v),
    .lim (cells[2].lim),
    .y   (horiz)
  );

  always_comb begin
    phase_next = phase;
    emit       = 1'b0;
    emit_done  = 1'b0;
    emit_blast = 1'b0;
    unique case (phase)
      tsf_pkg::PH_MAIN: begin
        emit       = (seen == tsf_pkg::SeenMax);
        emit_blast = !in_last;
        phase_next = in_last ? tsf_pkg::PH_FLUSH1 : tsf_pkg::PH_MAIN;
      end
      tsf_pkg::PH_FLUSH1: begin
        emit       = (seen != '0);
        phase_next = tsf_pkg::PH_FLUSH2;
      end
      tsf_pkg::PH_FLUSH2: begin
        emit       = 1'b1;
        emit_done  = 1'b1;
        emit_blast = 1'b1;
        phase_next = tsf_pkg::PH_MAIN;
      end
      default: begin
        phase_next = tsf_pkg::PH_MAIN;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= tsf_pkg::PH_MAIN;
      seen  <= '0;
    end else begin
      if (step) begin
        phase <= phase_next;
      end
      if (consume) begin
        if (in_last) begin
          seen <= '0;
        end else if (seen != tsf_pkg::SeenMax) begin
          seen <= seen + 2'd1;
        end
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!out_valid || result.ready) begin
      out_valid <= step && emit;
    end
  end

  always_ff @(posedge clk) begin
    if (step && emit) begin
      out_pix   <= horiz;
      out_done  <= emit_done;
      out_blast <= emit_blast;
    end
  end

  assign result.valid      = out_valid;
  assign result.out_pixel  = out_pix;
  assign result.row_done   = out_done;
  assign result.burst_last = out_blast;

  a_flush_owned: assert property (@(posedge clk) disable iff (rst)
    (phase != tsf_pkg::PH_MAIN) |-> (in_valid && in_last))
    else $error("flush phase without a pending row end");

  a_row_restart: assert property (@(posedge clk) disable iff (rst)
    (consume && in_last) |=> (seen == '0))
    else $error("column count not cleared at row end");

  a_flush_result: assert property (@(posedge clk) disable iff (rst)
    (step && (phase == tsf_pkg::PH_FLUSH2)) |=>
      (result.valid && result.row_done && result.burst_last))
    else $error("final flush step did not present the row's last pixel");

  a_done_closes: assert property (@(posedge clk) disable iff (rst)
    (result.valid && result.row_done) |-> result.burst_last)
    else $error("row_done without burst_last");

endmodule

`default_nettype wire
